### design/hss_pkg.sv
// ----------------------------------------------------------------------------
// hss_pkg
// Types and constants shared by the Horspool substring search block.
// ----------------------------------------------------------------------------
package hss_pkg;

  localparam int PposW      = 6;
  localparam int ByteW      = 8;
  localparam int LenRegW    = 7;
  localparam int ShiftW     = 7;
  localparam int MatchPosW  = 32;

  localparam logic ModeLoad = 1'b0;
  localparam logic ModeText = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [PposW-1:0]  pattern_position;
    logic [ByteW-1:0]  data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic                 found;
    logic [MatchPosW-1:0] match_position;
  } out_item_t;

endpackage

### design/hss_ram.sv
// ----------------------------------------------------------------------------
// hss_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module hss_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/horspool_substring_search.sv
// ----------------------------------------------------------------------------
// horspool_substring_search
// Finds the first occurrence of a loaded pattern in a text byte stream using
// the Boyer-Moore-Horspool bad-character rule.
// ----------------------------------------------------------------------------
// The input channel carries one item per transaction. A load item writes one
// pattern byte and updates the shift table; a text item appends one byte to
// the window ring. The first text item starts a search; the last-marked text
// item ends it with exactly one result transaction on the output channel.
// The pattern length register is written through the configuration channel,
// which is always ready and must only be used while the block is idle.
// A load item is captured in S_IDLE and carried out in S_EXEC, as is a text
// item that ends no alignment; when it does, the alignment check reads the
// pattern RAM and the window RAM one byte pair per cycle from the back and
// stops at the first mismatch. A last item then passes through S_RESULT,
// which moves the result into the output register.
// Reset clears the shift-valid flags, the search state and the output; the
// pattern and window RAMs need no clearing. The output register frees the
// input side: items are taken while a result waits, and only a second result
// waits in its own state until the receiver takes the first.
// ----------------------------------------------------------------------------
module horspool_substring_search #(
  parameter int MaxPattern    = 64,
  parameter int AlphabetSize  = 256,
  parameter int TextIndexBits = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  hss_pkg::in_item_t          in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output hss_pkg::out_item_t         out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [hss_pkg::LenRegW-1:0] cfg_data_i
);

  import hss_pkg::*;

  localparam int AW   = $clog2(MaxPattern);
  localparam int SAW  = $clog2(AlphabetSize);
  localparam int LenW = $clog2(MaxPattern + 1);
  localparam int SW   = (LenW > ShiftW) ? LenW : ShiftW;
  localparam int TIB  = TextIndexBits;
  localparam int CW   = TextIndexBits + 1;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;

  logic [1:0]              state_q, state_d;
  in_item_t                item_q, item_d;
  logic [LenRegW-1:0]      pattern_length_q, pattern_length_d;
  logic [AlphabetSize-1:0] shift_valid_q, shift_valid_d;
  logic                    search_active_q, search_active_d;
  logic                    match_seen_q, match_seen_d;
  logic [TIB-1:0]          first_match_q, first_match_d;
  logic [TIB-1:0]          text_count_q, text_count_d;
  logic [CW-1:0]           next_check_q, next_check_d;
  logic [AW-1:0]           wptr_q, wptr_d;
  logic [TIB-1:0]          t_q, t_d;
  logic [AW-1:0]           wpos_q, wpos_d;
  logic [AW-1:0]           pidx_q, pidx_d;
  logic [LenW-1:0]         remaining_q, remaining_d;
  logic                    rd_valid_q, rd_valid_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_data_q, out_data_d;

  logic [LenW-1:0]         len;
  logic                    byte_in_alph;
  logic [SAW-1:0]          byte_idx;
  logic [SW-1:0]           shift_val;

  logic                    pat_we, pat_re;
  logic [AW-1:0]           pat_waddr;
  logic [ByteW-1:0]        pat_rdata;
  logic                    win_we, win_re;
  logic [ByteW-1:0]        win_rdata;
  logic                    shift_we, shift_re;
  logic [ShiftW-1:0]       shift_wdata, shift_rdata;

  logic                    act;
  logic [TIB-1:0]          cnt_e, first_e;
  logic                    seen_e;
  logic [CW-1:0]           nchk_e;
  logic [AW-1:0]           wptr_e;
  logic                    finish;

  always_comb begin
    if (pattern_length_q == '0) begin
      len = LenW'(1);
    end else if (int'(pattern_length_q) > MaxPattern) begin
      len = LenW'(MaxPattern);
    end else begin
      len = LenW'(pattern_length_q);
    end
  end

  assign byte_in_alph = int'(item_q.data_byte) < AlphabetSize;
  assign byte_idx     = SAW'(item_q.data_byte);
  assign pat_waddr    = AW'(item_q.pattern_position);
  assign shift_wdata  = pattern_length_q - LenRegW'(item_q.pattern_position) - LenRegW'(1);

  always_comb begin
    if (byte_in_alph && shift_valid_q[byte_idx] && (shift_rdata != '0)) begin
      shift_val = SW'(shift_rdata);
    end else begin
      shift_val = SW'(len);
    end
  end

  assign act     = search_active_q;
  assign cnt_e   = act ? text_count_q : '0;
  assign seen_e  = act ? match_seen_q : 1'b0;
  assign first_e = act ? first_match_q : '0;
  assign nchk_e  = act ? next_check_q : (CW'(len) - CW'(1));
  assign wptr_e  = act ? wptr_q : '0;

  always_comb begin
    state_d          = state_q;
    item_d           = item_q;
    pattern_length_d = pattern_length_q;
    shift_valid_d    = shift_valid_q;
    search_active_d  = search_active_q;
    match_seen_d     = match_seen_q;
    first_match_d    = first_match_q;
    text_count_d     = text_count_q;
    next_check_d     = next_check_q;
    wptr_d           = wptr_q;
    t_d              = t_q;
    wpos_d           = wpos_q;
    pidx_d           = pidx_q;
    remaining_d      = remaining_q;
    rd_valid_d       = 1'b0;
    out_valid_d      = out_valid_q && !out_ready_i;
    out_data_d       = out_data_q;
    pat_we           = 1'b0;
    pat_re           = 1'b0;
    win_we           = 1'b0;
    win_re           = 1'b0;
    shift_we         = 1'b0;
    shift_re         = 1'b0;
    finish           = 1'b0;

    if (cfg_valid_i) begin
      pattern_length_d = cfg_data_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_q.mode == ModeLoad) begin
          pat_we = int'(item_q.pattern_position) < MaxPattern;
          if (item_q.pattern_position == '0) begin
            shift_valid_d = '0;
          end
          if (byte_in_alph &&
              (({1'b0, item_q.pattern_position} + LenRegW'(1)) < pattern_length_q)) begin
            shift_we                = 1'b1;
            shift_valid_d[byte_idx] = 1'b1;
          end
          state_d = S_IDLE;
        end else begin
          search_active_d = 1'b1;
          match_seen_d    = seen_e;
          first_match_d   = first_e;
          next_check_d    = nchk_e;
          text_count_d    = cnt_e;
          wptr_d          = wptr_e;
          finish          = 1'b1;
          if (cnt_e != '1) begin
            win_we       = 1'b1;
            text_count_d = cnt_e + TIB'(1);
            wptr_d       = (int'(wptr_e) == MaxPattern - 1) ? '0 : wptr_e + AW'(1);
            t_d          = cnt_e;
            if (!seen_e && ({1'b0, cnt_e} == nchk_e)) begin
              if (({1'b0, cnt_e} + CW'(1)) < CW'(len)) begin
                next_check_d = CW'(len) - CW'(1);
              end else begin
                finish      = 1'b0;
                shift_re    = 1'b1;
                wpos_d      = wptr_e;
                pidx_d      = AW'(len - LenW'(1));
                remaining_d = len;
                state_d     = S_CMP;
              end
            end
          end
        end
      end
      S_CMP: begin
        if (rd_valid_q && (win_rdata != pat_rdata)) begin
          next_check_d = {1'b0, t_q} + CW'(shift_val);
          finish       = 1'b1;
        end else if (rd_valid_q && (remaining_q == '0)) begin
          match_seen_d  = 1'b1;
          first_match_d = t_q - TIB'(len - LenW'(1));
          finish        = 1'b1;
        end else if (remaining_q != '0) begin
          pat_re      = 1'b1;
          win_re      = 1'b1;
          wpos_d      = (wpos_q == '0) ? AW'(MaxPattern - 1) : wpos_q - AW'(1);
          pidx_d      = pidx_q - AW'(1);
          remaining_d = remaining_q - LenW'(1);
          rd_valid_d  = 1'b1;
        end
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d               = 1'b1;
          out_data_d.found          = match_seen_q;
          out_data_d.match_position = match_seen_q ? MatchPosW'(first_match_q) : '0;
          search_active_d           = 1'b0;
          state_d                   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (finish) begin
      state_d = item_q.last_byte ? S_RESULT : S_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      pattern_length_q <= LenRegW'(1);
      shift_valid_q    <= '0;
      search_active_q  <= 1'b0;
      match_seen_q     <= 1'b0;
      first_match_q    <= '0;
      text_count_q     <= '0;
      next_check_q     <= '0;
      wptr_q           <= '0;
      remaining_q      <= '0;
      rd_valid_q       <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      state_q          <= state_d;
      pattern_length_q <= pattern_length_d;
      shift_valid_q    <= shift_valid_d;
      search_active_q  <= search_active_d;
      match_seen_q     <= match_seen_d;
      first_match_q    <= first_match_d;
      text_count_q     <= text_count_d;
      next_check_q     <= next_check_d;
      wptr_q           <= wptr_d;
      remaining_q      <= remaining_d;
      rd_valid_q       <= rd_valid_d;
      out_valid_q      <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    t_q        <= t_d;
    wpos_q     <= wpos_d;
    pidx_q     <= pidx_d;
    out_data_q <= out_data_d;
  end

  hss_ram #(
    .Width(ByteW),
    .Depth(MaxPattern)
  ) u_pattern_ram (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(pat_waddr),
    .wdata_i(item_q.data_byte),
    .re_i   (pat_re),
    .raddr_i(pidx_q),
    .rdata_o(pat_rdata)
  );

  hss_ram #(
    .Width(ByteW),
    .Depth(MaxPattern)
  ) u_window_ram (
    .clk_i  (clk_i),
    .we_i   (win_we),
    .waddr_i(wptr_e),
    .wdata_i(item_q.data_byte),
    .re_i   (win_re),
    .raddr_i(wpos_q),
    .rdata_o(win_rdata)
  );

  hss_ram #(
    .Width(ShiftW),
    .Depth(AlphabetSize)
  ) u_shift_ram (
    .clk_i  (clk_i),
    .we_i   (shift_we),
    .waddr_i(byte_idx),
    .wdata_i(shift_wdata),
    .re_i   (shift_re),
    .raddr_i(byte_idx),
    .rdata_o(shift_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### bench/tb_horspool_substring_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_horspool_substring_search
// Self-checking bench for the Horspool substring search block.
// ----------------------------------------------------------------------------
// Pattern loads and text streams are queued up front and driven with random
// gaps. A bit-accurate model of the search predicts every result when its
// transaction is accepted, and a monitor compares results against that model
// while stalling the output channel at random. The pattern length is changed
// between searches and once in a while in the middle of one.
// ----------------------------------------------------------------------------
module tb_horspool_substring_search;
  import hss_pkg::*;

  localparam int MaxPat        = 64;
  localparam int SettleCycles  = MaxPat + 16;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 2000;
  localparam int ItemTarget    = 1200;
  localparam int SearchTarget  = 40;
  localparam longint unsigned IndexLimit = (64'd1 << 32) - 1;

  typedef enum logic [1:0] {
    STEP_ITEM,
    STEP_CFG,
    STEP_DRAIN,
    STEP_HOLD
  } step_kind_e;

  typedef struct packed {
    step_kind_e         kind;
    in_item_t           item;
    logic [3:0]         gap;
    logic [LenRegW-1:0] cfg_value;
  } step_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LenRegW-1:0] cfg_data_i = '0;
  logic               hold_req = 1'b0;

  // Search model state.
  logic [7:0]         pat_mem [MaxPat];
  logic [6:0]         skip_tbl [256];
  bit                 skip_ok [256];
  logic [7:0]         win_mem [MaxPat];
  longint unsigned    txt_cnt;
  longint unsigned    chk_at;
  longint unsigned    first_at;
  bit                 in_search;
  bit                 hit_seen;
  logic [LenRegW-1:0] len_reg = 7'd1;
  out_item_t          expected_reports [$];

  // Stimulus plan.
  step_t              stim_q [$];
  logic [7:0]         plan_pat [MaxPat];
  bit [MaxPat-1:0]    plan_written;
  int unsigned        plan_len_raw = 1;
  int unsigned        planned_items;
  logic [7:0]         sym_pool [4];
  bit                 wide_bytes;

  int                 gap_left = -1;
  int                 quiet_cycles;
  int                 rx_wait;
  int                 rx_calm_left;
  int                 hold_left;
  int                 idle_cycles;
  int                 err_cnt;
  int                 loads_seen;
  int                 texts_seen;
  int                 searches_done;
  int                 matches_done;
  int                 cfg_writes;
  int                 len_min = 127;
  int                 len_max;

  horspool_substring_search #(
    .MaxPattern   (MaxPat),
    .AlphabetSize (256),
    .TextIndexBits(32)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_len(int unsigned raw);
    if (raw < 1) begin
      return 1;
    end
    if (raw > MaxPat) begin
      return MaxPat;
    end
    return raw;
  endfunction

  task automatic log_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    err_cnt++;
  endtask

  // Advances the search model by one accepted transaction.
  task automatic track_search(input in_item_t it);
    int unsigned     len;
    int unsigned     ppos;
    int unsigned     j;
    logic [31:0]     shift_val;
    longint unsigned t;
    longint unsigned start;
    logic [7:0]      tail;
    bit              hit;
    out_item_t       rep;
    if (it.mode == ModeLoad) begin
      ppos = it.pattern_position;
      if (ppos == 0) begin
        foreach (skip_ok[i]) skip_ok[i] = 1'b0;
      end
      pat_mem[ppos] = it.data_byte;
      if (ppos + 1 < len_reg) begin
        shift_val = len_reg - 1 - ppos;
        skip_tbl[it.data_byte] = shift_val[6:0];
        skip_ok[it.data_byte] = 1'b1;
      end
      loads_seen++;
    end else begin
      texts_seen++;
      len = clamp_len(len_reg);
      if (!in_search) begin
        in_search = 1'b1;
        txt_cnt = 0;
        hit_seen = 1'b0;
        first_at = 0;
        chk_at = len - 1;
      end
      if (txt_cnt < IndexLimit) begin
        t = txt_cnt;
        win_mem[t % MaxPat] = it.data_byte;
        txt_cnt = t + 1;
        if (!hit_seen && t == chk_at) begin
          if (t + 1 < len) begin
            chk_at = len - 1;
          end else begin
            start = t + 1 - len;
            hit = 1'b1;
            j = len;
            while (hit && j > 0) begin
              if (win_mem[(start + j - 1) % MaxPat] != pat_mem[j - 1]) begin
                hit = 1'b0;
              end
              j--;
            end
            if (hit) begin
              hit_seen = 1'b1;
              first_at = start;
            end else begin
              tail = win_mem[t % MaxPat];
              if (skip_ok[tail] && skip_tbl[tail] != 0) begin
                chk_at = t + skip_tbl[tail];
              end else begin
                chk_at = t + len;
              end
            end
          end
        end
      end
      if (it.last_byte) begin
        rep.found = hit_seen;
        rep.match_position = hit_seen ? first_at[31:0] : '0;
        expected_reports.push_back(rep);
        in_search = 1'b0;
        searches_done++;
        if (hit_seen) begin
          matches_done++;
        end
      end
    end
  endtask

  task automatic queue_item(logic mode, int unsigned ppos, logic [7:0] data, logic is_last,
                            int unsigned gap);
    step_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.item.mode = mode;
    s.item.pattern_position = ppos[PposW-1:0];
    s.item.data_byte = data;
    s.item.last_byte = is_last;
    s.gap = gap[3:0];
    stim_q.push_back(s);
    planned_items++;
    if (mode == ModeLoad) begin
      plan_pat[ppos] = data;
      plan_written[ppos] = 1'b1;
    end
  endtask

  task automatic queue_control(step_kind_e kind, int unsigned value);
    step_t s;
    s = '0;
    s.kind = kind;
    s.cfg_value = value[LenRegW-1:0];
    stim_q.push_back(s);
    if (kind == STEP_CFG) begin
      plan_len_raw = value;
    end
  endtask

  function automatic logic [7:0] pick_byte();
    if (wide_bytes) begin
      return 8'($urandom_range(0, 255));
    end
    return sym_pool[$urandom_range(0, 3)];
  endfunction

  // Queues one search's text bytes, the last one marked, with optional stray
  // loads and an optional shorter pattern length halfway through.
  task automatic queue_bytes(input logic [7:0] txt [$], bit noisy, bit calm, bit shrink);
    int unsigned k;
    int unsigned len;
    int unsigned gap;
    for (k = 0; k < txt.size(); k++) begin
      gap = calm ? 0 : $urandom_range(0, 8);
      if (noisy && $urandom_range(0, 9) == 0) begin
        queue_item(ModeLoad, $urandom_range(0, MaxPat - 1), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), gap);
      end
      len = clamp_len(plan_len_raw);
      if (shrink && k == txt.size() / 2 && k + 1 < txt.size() && len > 1) begin
        queue_control(STEP_CFG, $urandom_range(1, len - 1));
      end
      queue_item(ModeText, $urandom_range(0, MaxPat - 1), txt[k], k + 1 == txt.size(), gap);
    end
  endtask

  task automatic queue_search(int unsigned text_len, bit plant, bit noisy, bit calm,
                              bit shrink);
    logic [7:0]  txt [$];
    int unsigned len;
    int unsigned ofs;
    int unsigned k;
    len = clamp_len(plan_len_raw);
    for (k = 0; k < text_len; k++) txt.push_back(pick_byte());
    if (plant && text_len >= len) begin
      repeat ($urandom_range(1, 2)) begin
        ofs = $urandom_range(0, text_len - len);
        for (k = 0; k < len; k++) txt[ofs + k] = plan_pat[k];
      end
    end
    queue_bytes(txt, noisy, calm, shrink);
  endtask

  task automatic queue_pattern(bit shuffled, bit calm);
    int unsigned len;
    int unsigned k;
    int unsigned j;
    int unsigned tmp;
    int unsigned order [MaxPat];
    wide_bytes = ($urandom_range(0, 4) == 0);
    foreach (sym_pool[i]) sym_pool[i] = 8'($urandom_range(0, 255));
    len = clamp_len(plan_len_raw);
    for (k = 0; k < len; k++) order[k] = k;
    if (shuffled) begin
      for (k = 0; k < len; k++) begin
        j = $urandom_range(0, len - 1);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    for (k = 0; k < len; k++) begin
      queue_item(ModeLoad, order[k], pick_byte(), 1'($urandom_range(0, 1)),
                 calm ? 0 : $urandom_range(0, 8));
    end
  endtask

  always @(posedge clk_i) begin : driver
    logic               valid_nxt;
    logic               cfg_nxt;
    logic               hold_nxt;
    in_item_t           data_nxt;
    logic [LenRegW-1:0] cfg_data_nxt;
    valid_nxt = in_valid_i;
    cfg_nxt = cfg_valid_i;
    hold_nxt = 1'b0;
    data_nxt = in_data_i;
    cfg_data_nxt = cfg_data_i;
    if (rst_ni) begin
      quiet_cycles++;
      if (in_valid_i && in_ready_o) begin
        track_search(in_data_i);
        valid_nxt = 1'b0;
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        len_reg = cfg_data_i;
        cfg_nxt = 1'b0;
        cfg_writes++;
        if (cfg_data_i < len_min) len_min = cfg_data_i;
        if (cfg_data_i > len_max) len_max = cfg_data_i;
      end
      if (!valid_nxt && !cfg_nxt && stim_q.size() != 0) begin
        case (stim_q[0].kind)
          STEP_ITEM: begin
            if (gap_left < 0) begin
              gap_left = stim_q[0].gap;
            end
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              data_nxt = stim_q[0].item;
              valid_nxt = 1'b1;
              gap_left = -1;
              void'(stim_q.pop_front());
            end
          end
          STEP_CFG: begin
            if (expected_reports.size() == 0 && quiet_cycles >= SettleCycles) begin
              cfg_data_nxt = stim_q[0].cfg_value;
              cfg_nxt = 1'b1;
              void'(stim_q.pop_front());
            end
          end
          STEP_DRAIN: begin
            if (expected_reports.size() == 0) begin
              void'(stim_q.pop_front());
            end
          end
          default: begin
            hold_nxt = 1'b1;
            void'(stim_q.pop_front());
          end
        endcase
      end
    end
    in_valid_i <= valid_nxt;
    in_data_i <= data_nxt;
    cfg_valid_i <= cfg_nxt;
    cfg_data_i <= cfg_data_nxt;
    hold_req <= hold_nxt;
  end

  always @(posedge clk_i) begin : monitor
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_reports.size() == 0) begin
          log_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                 out_data_o.found, out_data_o.match_position));
        end else begin
          want = expected_reports.pop_front();
          if (out_data_o.found !== want.found) begin
            log_mismatch($sformatf("found is %0b, expected %0b",
                                   out_data_o.found, want.found));
          end
          if (out_data_o.match_position !== want.match_position) begin
            log_mismatch($sformatf("match_position is %0d, expected %0d",
                                   out_data_o.match_position, want.match_position));
          end
        end
        if (rx_calm_left > 0) begin
          rx_calm_left--;
          rx_wait = 0;
        end else begin
          rx_wait = $urandom_range(0, 8);
          if ($urandom_range(0, 7) == 0) begin
            rx_calm_left = 10;
          end
        end
      end
      if (hold_req) begin
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (hold_left == 0) && (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog: %0d cycles without a transaction, %0d results outstanding",
                 idle_cycles, expected_reports.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  dir_txt [$];
    int unsigned search_no;
    int unsigned raw;
    int unsigned len;
    int unsigned r;
    int unsigned k;
    int unsigned text_len;
    bit          fresh;
    bit          calm;
    rst_ni = 1'b0;

    // Directed: matches at the start and further in, short texts, a load
    // carrying a last mark, a zero length, and the top pattern position.
    queue_control(STEP_CFG, 3);
    queue_item(ModeLoad, 0, 8'h00, 1'b0, $urandom_range(0, 8));
    queue_item(ModeLoad, 1, 8'hFF, 1'b1, $urandom_range(0, 8));
    queue_item(ModeLoad, 2, 8'h5A, 1'b0, $urandom_range(0, 8));
    dir_txt = '{8'h00, 8'hFF, 8'h5A, 8'h00};
    queue_bytes(dir_txt, 1'b0, 1'b0, 1'b0);
    dir_txt = '{8'h00, 8'hFF};
    queue_bytes(dir_txt, 1'b0, 1'b0, 1'b0);
    dir_txt = '{8'h5A, 8'h5A, 8'h00, 8'hFF, 8'h5A, 8'h11};
    queue_bytes(dir_txt, 1'b0, 1'b0, 1'b0);
    queue_control(STEP_CFG, 0);
    dir_txt = '{8'hFF, 8'h5A, 8'h00};
    queue_bytes(dir_txt, 1'b0, 1'b0, 1'b0);
    queue_item(ModeLoad, MaxPat - 1, 8'hFF, 1'b1, $urandom_range(0, 8));
    queue_item(ModeLoad, MaxPat - 1, 8'h00, 1'b0, $urandom_range(0, 8));
    queue_control(STEP_CFG, 1);
    dir_txt = '{8'h00};
    queue_bytes(dir_txt, 1'b0, 1'b0, 1'b0);

    search_no = 0;
    while (planned_items < ItemTarget || search_no < SearchTarget) begin
      if (search_no < 4) begin
        case (search_no)
          0: raw = 64;
          1: raw = 127;
          2: raw = 0;
          default: raw = 1;
        endcase
        queue_control(STEP_CFG, raw);
      end else if ($urandom_range(0, 9) < 4) begin
        r = $urandom_range(0, 15);
        if (r < 8) begin
          raw = $urandom_range(1, 6);
        end else if (r < 12) begin
          raw = $urandom_range(7, 16);
        end else if (r < 14) begin
          raw = $urandom_range(17, 64);
        end else begin
          raw = (r == 14) ? 0 : 127;
        end
        queue_control(STEP_CFG, raw);
      end
      len = clamp_len(plan_len_raw);
      fresh = ($urandom_range(0, 4) != 0);
      for (k = 0; k < len; k++) begin
        if (!plan_written[k]) fresh = 1'b1;
      end
      calm = ($urandom_range(0, 3) == 0);
      if (fresh) begin
        queue_pattern($urandom_range(0, 5) == 0, calm);
      end
      if (search_no == 8) begin
        // The receiver stops for a long stretch while short searches keep
        // coming, then the sender waits for every result.
        queue_control(STEP_HOLD, 0);
        repeat (8) queue_search($urandom_range(1, 3), 1'b1, 1'b0, 1'b1, 1'b0);
        queue_control(STEP_DRAIN, 0);
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          queue_control(STEP_DRAIN, 0);
        end
        if ($urandom_range(0, 9) == 0) begin
          text_len = $urandom_range(64, 150);
        end else begin
          text_len = $urandom_range(1, 2 * len + 12);
        end
        queue_search(text_len, $urandom_range(0, 9) < 6, $urandom_range(0, 9) == 0, calm,
                     $urandom_range(0, 11) == 0);
      end
      search_no++;
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || cfg_valid_i || expected_reports.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("Run covered %0d pattern loads and %0d text bytes in %0d searches, %0d found.",
             loads_seen, texts_seen, searches_done, matches_done);
    $display("Pattern length was written %0d times with values from %0d to %0d.",
             cfg_writes, len_min, len_max);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
